@@ hw/rtl/irlp_pkg.sv @@
// ----------------------------------------------------------------------------
// IMAP response line parser package
// Shared types, character codes, result codes and the keyword table.
// ----------------------------------------------------------------------------
package irlp_pkg;

    localparam int NUMBER_BITS_DEF = 32;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic        tag_kind;
        logic [31:0] tag_value;
        logic [1:0]  response_code;
        logic [2:0]  command_code;
        logic [31:0] count_value;
    } t_out_item;

    typedef enum logic [3:0] {
        PH_START,
        PH_TAG,
        PH_GAP,
        PH_WORD,
        PH_NUM,
        PH_CMD,
        PH_SGAP,
        PH_SNUM,
        PH_TEXT
    } t_phase;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [1:0] RESP_NONE = 2'd0;
    localparam logic [1:0] RESP_OK   = 2'd1;
    localparam logic [1:0] RESP_NO   = 2'd2;
    localparam logic [1:0] RESP_BAD  = 2'd3;

    localparam logic [2:0] CMD_UNKNOWN = 3'd0;
    localparam logic [2:0] CMD_EXPUNGE = 3'd1;
    localparam logic [2:0] CMD_RECENT  = 3'd2;
    localparam logic [2:0] CMD_EXISTS  = 3'd3;
    localparam logic [2:0] CMD_FETCH   = 3'd4;
    localparam logic [2:0] CMD_SEARCH  = 3'd5;

    localparam logic [2:0] KW_OK      = 3'd0;
    localparam logic [2:0] KW_NO      = 3'd1;
    localparam logic [2:0] KW_BAD     = 3'd2;
    localparam logic [2:0] KW_EXPUNGE = 3'd3;
    localparam logic [2:0] KW_RECENT  = 3'd4;
    localparam logic [2:0] KW_EXISTS  = 3'd5;
    localparam logic [2:0] KW_FETCH   = 3'd6;
    localparam logic [2:0] KW_SEARCH  = 3'd7;

    localparam logic [2:0] KW_POS_END = 3'd7;

    localparam logic [7:0] CAND_ALL    = 8'hFF;
    localparam logic [7:0] CAND_RESP   = 8'h87;
    localparam logic [7:0] CAND_CMD    = 8'h78;
    localparam logic [7:0] CAND_SEARCH = 8'h80;

    // Each keyword is left-justified in seven character slots.
    localparam logic [7:0][55:0] KW_TEXT = '{
        {"SEARCH", 8'h00},
        {"FETCH", 16'h0000},
        {"EXISTS", 8'h00},
        {"RECENT", 8'h00},
        "EXPUNGE",
        {"BAD", 32'h0000_0000},
        {"NO", 40'h00_0000_0000},
        {"OK", 40'h00_0000_0000}
    };

    localparam logic [7:0][2:0] KW_LEN = '{
        3'd6, 3'd5, 3'd6, 3'd6, 3'd7, 3'd3, 3'd2, 3'd2
    };

    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] pos);
        logic [55:0] sh;
        sh = KW_TEXT[k] << {pos, 3'b000};
        return sh[55:48];
    endfunction

endpackage

@@ hw/rtl/irlp_parse.sv @@
// ----------------------------------------------------------------------------
// IMAP response line parser state
// Holds the per-line parse state and advances it by one byte per step.
// ----------------------------------------------------------------------------
module irlp_parse #(
    parameter int NUMBER_BITS = irlp_pkg::NUMBER_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  irlp_pkg::t_in_item   i_item,
    output logic                 o_emit,
    output irlp_pkg::t_out_item  o_result
);

    typedef logic [NUMBER_BITS-1:0] t_num;

    typedef struct packed {
        irlp_pkg::t_phase phase;
        t_num             tag_accum;
        logic             tag_is_numeric;
        logic [1:0]       response_reg;
        logic [7:0]       keyword_candidates;
        logic [2:0]       keyword_position;
        t_num             number_accum;
        logic [2:0]       command_reg;
        logic             line_open;
    } t_state;

    typedef struct packed {
        logic                emit;
        irlp_pkg::t_out_item res;
        t_state              st;
    } t_feed;

    t_state r_state;
    t_state n_state;
    t_feed  w_feed;
    logic   w_close;

    function automatic t_state cleared();
        t_state s;
        s.phase              = irlp_pkg::PH_START;
        s.tag_accum          = '0;
        s.tag_is_numeric     = 1'b0;
        s.response_reg       = irlp_pkg::RESP_NONE;
        s.keyword_candidates = irlp_pkg::CAND_ALL;
        s.keyword_position   = 3'd0;
        s.number_accum       = '0;
        s.command_reg        = irlp_pkg::CMD_UNKNOWN;
        s.line_open          = 1'b0;
        return s;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= irlp_pkg::CH_ZERO) && (c <= irlp_pkg::CH_NINE);
    endfunction

    function automatic logic is_eol(input logic [7:0] c);
        return (c == irlp_pkg::CH_CR) || (c == irlp_pkg::CH_LF);
    endfunction

    function automatic t_num sat_digit(input t_num acc, input logic [7:0] c);
        logic [NUMBER_BITS+3:0] wide;
        logic [NUMBER_BITS+3:0] prod;
        wide = (NUMBER_BITS+4)'(acc);
        prod = (wide << 3) + (wide << 1) + (NUMBER_BITS+4)'(c[3:0]);
        if (prod[NUMBER_BITS+3:NUMBER_BITS] != 4'd0) begin
            return '1;
        end
        return prod[NUMBER_BITS-1:0];
    endfunction

    function automatic t_num sat_inc(input t_num v);
        return (v == '1) ? v : v + t_num'(1);
    endfunction

    function automatic logic [7:0] word_cands(input logic [7:0] cands,
                                              input logic [2:0] pos,
                                              input logic [7:0] c);
        logic [7:0] keep;
        keep = 8'd0;
        if (pos != irlp_pkg::KW_POS_END) begin
            for (int k = 0; k < 8; k++) begin
                keep[k] = cands[k] && (pos < irlp_pkg::KW_LEN[k]) &&
                          (irlp_pkg::kw_char(3'(k), pos) == c);
            end
        end
        return keep;
    endfunction

    function automatic logic [2:0] word_pos(input logic [2:0] pos);
        return (pos == irlp_pkg::KW_POS_END) ? pos : pos + 3'd1;
    endfunction

    // Bit 3 flags a match and bits 2:0 give the keyword index.
    function automatic logic [3:0] find_exact(input logic [7:0] cands,
                                              input logic [2:0] pos);
        logic [3:0] r;
        r = 4'd0;
        for (int k = 7; k >= 0; k--) begin
            if (cands[k] && (irlp_pkg::KW_LEN[k] == pos)) begin
                r = {1'b1, 3'(k)};
            end
        end
        return r;
    endfunction

    function automatic t_state resolve(input t_state s);
        t_state     r;
        logic [3:0] m;
        logic [2:0] k;
        r = s;
        m = find_exact(s.keyword_candidates, s.keyword_position);
        k = m[2:0];
        if (s.phase == irlp_pkg::PH_WORD) begin
            if (s.response_reg == irlp_pkg::RESP_NONE && m[3] &&
                (k == irlp_pkg::KW_OK || k == irlp_pkg::KW_NO || k == irlp_pkg::KW_BAD)) begin
                r.response_reg = 2'(k + 3'd1);
                r.phase        = irlp_pkg::PH_GAP;
            end else if (m[3] && k == irlp_pkg::KW_SEARCH) begin
                r.command_reg  = irlp_pkg::CMD_SEARCH;
                r.number_accum = '0;
                r.phase        = irlp_pkg::PH_SGAP;
            end else begin
                r.phase = irlp_pkg::PH_TEXT;
            end
        end else if (s.phase == irlp_pkg::PH_CMD) begin
            if (m[3] && (k == irlp_pkg::KW_EXPUNGE || k == irlp_pkg::KW_RECENT ||
                         k == irlp_pkg::KW_EXISTS || k == irlp_pkg::KW_FETCH)) begin
                r.command_reg = k - 3'd2;
            end else begin
                r.command_reg = irlp_pkg::CMD_UNKNOWN;
            end
            r.phase = irlp_pkg::PH_TEXT;
        end
        return r;
    endfunction

    function automatic irlp_pkg::t_out_item finish(input t_state s);
        irlp_pkg::t_out_item o;
        t_state              r;
        r               = resolve(s);
        o.tag_kind      = r.tag_is_numeric;
        o.tag_value     = 32'(r.tag_accum);
        o.response_code = r.response_reg;
        o.command_code  = r.command_reg;
        o.count_value   = 32'(r.number_accum);
        return o;
    endfunction

    function automatic t_state gap_char(input t_state s, input logic [7:0] c);
        t_state r;
        r = s;
        if (is_digit(c)) begin
            if (s.response_reg == irlp_pkg::RESP_NONE) begin
                r.number_accum = t_num'(c[3:0]);
                r.phase        = irlp_pkg::PH_NUM;
            end else begin
                r.phase = irlp_pkg::PH_TEXT;
            end
        end else begin
            r.keyword_candidates = word_cands(
                (s.response_reg == irlp_pkg::RESP_NONE) ? irlp_pkg::CAND_RESP
                                                         : irlp_pkg::CAND_SEARCH,
                3'd0, c);
            r.keyword_position = 3'd1;
            r.phase            = irlp_pkg::PH_WORD;
        end
        return r;
    endfunction

    function automatic t_feed feed(input t_state s, input logic [7:0] c);
        t_feed f;
        logic  eol;
        logic  dig;
        logic  sp;
        eol    = is_eol(c);
        dig    = is_digit(c);
        sp     = (c == irlp_pkg::CH_SPACE);
        f.emit = 1'b0;
        f.res  = '0;
        f.st   = s;
        if (eol && s.phase != irlp_pkg::PH_START) begin
            f.emit = 1'b1;
            f.res  = finish(s);
            f.st   = cleared();
        end else begin
            unique case (s.phase)
                irlp_pkg::PH_START: begin
                    if (!sp && !eol) begin
                        f.st.line_open = 1'b1;
                        if (c == irlp_pkg::CH_STAR || c == irlp_pkg::CH_PLUS) begin
                            f.st.phase = irlp_pkg::PH_GAP;
                        end else if (dig) begin
                            f.st.tag_is_numeric = 1'b1;
                            f.st.tag_accum      = t_num'(c[3:0]);
                            f.st.phase          = irlp_pkg::PH_TAG;
                        end else begin
                            f.st = gap_char(f.st, c);
                        end
                    end
                end
                irlp_pkg::PH_TAG: begin
                    if (dig) begin
                        f.st.tag_accum = sat_digit(s.tag_accum, c);
                    end else if (sp) begin
                        f.st.phase = irlp_pkg::PH_GAP;
                    end else begin
                        f.st = gap_char(s, c);
                    end
                end
                irlp_pkg::PH_GAP: begin
                    if (!sp) begin
                        f.st = gap_char(s, c);
                    end
                end
                irlp_pkg::PH_WORD, irlp_pkg::PH_CMD: begin
                    if (sp) begin
                        f.st = resolve(s);
                    end else begin
                        f.st.keyword_candidates =
                            word_cands(s.keyword_candidates, s.keyword_position, c);
                        f.st.keyword_position = word_pos(s.keyword_position);
                    end
                end
                irlp_pkg::PH_NUM: begin
                    if (dig) begin
                        f.st.number_accum = sat_digit(s.number_accum, c);
                    end else begin
                        f.st.keyword_candidates = irlp_pkg::CAND_CMD;
                        f.st.keyword_position   = 3'd0;
                        f.st.phase              = irlp_pkg::PH_CMD;
                    end
                end
                irlp_pkg::PH_SGAP, irlp_pkg::PH_SNUM: begin
                    if (sp) begin
                        f.st.phase = irlp_pkg::PH_SGAP;
                    end else if (dig) begin
                        if (s.phase == irlp_pkg::PH_SGAP) begin
                            f.st.number_accum = sat_inc(s.number_accum);
                        end
                        f.st.phase = irlp_pkg::PH_SNUM;
                    end else begin
                        f.st.phase = irlp_pkg::PH_TEXT;
                    end
                end
                default: begin
                    f.st = s;
                end
            endcase
        end
        return f;
    endfunction

    always_comb begin
        w_feed  = feed(r_state, i_item.byte_in);
        w_close = !w_feed.emit && i_item.last_byte && w_feed.st.line_open;
    end

    always_comb begin
        if (w_close) begin
            n_state = cleared();
        end else begin
            n_state = w_feed.st;
        end
    end

    always_comb begin
        o_emit   = w_feed.emit || w_close;
        o_result = w_feed.emit ? w_feed.res : finish(w_feed.st);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cleared();
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

endmodule

@@ hw/rtl/imap_response_line_parser_core.sv @@
// ----------------------------------------------------------------------------
// IMAP response line parser core
// Summarizes a server response byte stream into one result per non-blank line.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  input     in         i_in_valid / o_in_ready   i_in_data   (byte_in, last_byte)
//  result    out        o_out_valid / i_out_ready o_out_data  (one summary per line)
//
//  The core takes one byte per cycle and passes the byte that closes a line
//  through an input register and a result register to give its result.
//  Reset is synchronous and clears the line state and the valid flags of both registers.
//  A byte that closes a line waits in the input register while a result is
//  still held and not taken; other bytes keep flowing.
// ----------------------------------------------------------------------------
module imap_response_line_parser_core #(
    parameter int NUMBER_BITS = irlp_pkg::NUMBER_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  irlp_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output irlp_pkg::t_out_item o_out_data
);

    logic                r_in_valid;
    irlp_pkg::t_in_item  r_in_data;
    logic                r_out_valid;
    irlp_pkg::t_out_item r_out_data;

    logic                w_emit;
    irlp_pkg::t_out_item w_result;
    logic                w_out_free;
    logic                w_step;

    irlp_parse #(
        .NUMBER_BITS(NUMBER_BITS)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (r_in_data),
        .o_emit   (w_emit),
        .o_result (w_result)
    );

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_step      = r_in_valid && (!w_emit || w_out_free);
    assign o_in_ready  = !r_in_valid || w_step;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_step && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_data <= i_in_data;
        end
        if (w_step && w_emit) begin
            r_out_data <= w_result;
        end
    end

endmodule
